/* design/dpr_pkg.sv */
// Shared types, constants and constant functions of the duotone pixel remap block.
package dpr_pkg;

   // Component width and full-scale value.
   localparam int PIXEL_BITS = 8;
   localparam int MAXV = (1 << PIXEL_BITS) - 1;

   // Q0.16 constants.
   localparam int ONE_Q16 = 65536;
   localparam int MID_Q16 = 32768;

   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 3;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PRESET_SELECT = 3'd0,
      CSR_CUSTOM_SHADOW = 3'd1,
      CSR_CUSTOM_HIGHLIGHT = 3'd2,
      CSR_CONTRAST_GAIN = 3'd3,
      CSR_TONE_EXPONENT = 3'd4,
      CSR_MIX_AMOUNT = 3'd5
   } csr_index_type;

   typedef logic [PIXEL_BITS-1:0] comp_type;

   typedef struct packed {
      comp_type in_red;
      comp_type in_green;
      comp_type in_blue;
      comp_type in_alpha;
   } pixel_in_type;

   typedef struct packed {
      comp_type out_red;
      comp_type out_green;
      comp_type out_blue;
      comp_type out_alpha;
   } pixel_out_type;

   // Valid bit and source pixel that travel with every pipeline stage.
   typedef struct packed {
      logic valid;
      pixel_in_type pix;
   } tag_type;

   typedef struct packed {
      logic [3:0] preset_select;
      logic [23:0] custom_shadow_ink;
      logic [23:0] custom_highlight_ink;
      logic [15:0] contrast_gain;
      logic [15:0] tone_exponent;
      logic [16:0] mix_amount;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      preset_select: 4'd2,
      custom_shadow_ink: 24'h0F0E3D,
      custom_highlight_ink: 24'hFF3C82,
      contrast_gain: 16'd18022,
      tone_exponent: 16'd16384,
      mix_amount: 17'd65536
   };

   // Ink preset ROM: [preset][0 shadow, 1 highlight][red, green, blue].
   localparam logic [7:0] INK_ROM [8][2][3] = '{
      '{'{8'd10, 8'd30, 8'd70}, '{8'd225, 8'd240, 8'd250}},
      '{'{8'd35, 8'd20, 8'd5}, '{8'd255, 8'd235, 8'd200}},
      '{'{8'd15, 8'd10, 8'd60}, '{8'd255, 8'd60, 8'd130}},
      '{'{8'd45, 8'd10, 8'd90}, '{8'd60, 8'd230, 8'd240}},
      '{'{8'd8, 8'd12, 8'd8}, '{8'd140, 8'd255, 8'd60}},
      '{'{8'd20, 8'd0, 8'd5}, '{8'd255, 8'd80, 8'd40}},
      '{'{8'd40, 8'd15, 8'd50}, '{8'd250, 8'd200, 8'd90}},
      '{'{8'd25, 8'd35, 8'd50}, '{8'd220, 8'd230, 8'd240}}
   };

   // Integer square root, used only to build constants at elaboration.
   function automatic logic [63:0] isqrt64(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] v;
      r = '0;
      b = 64'd1 << 62;
      v = x;
      for (int s = 0; s < 32; s++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(idx+1)) in Q0.30, made by repeated square roots from 2^59.
   function automatic logic [29:0] tone_root(input int idx);
      logic [63:0] r;
      r = isqrt64(64'd1 << 59);
      for (int i = 1; i <= idx; i++) begin
         r = isqrt64(r << 30);
      end
      return r[29:0];
   endfunction

endpackage

/* design/dpr_luma.sv */
// Luma extraction and contrast stage group of the duotone pixel remap block.
module dpr_luma (
   input logic clock,
   input logic reset,
   input logic en,
   input dpr_pkg::tag_type tag_in,
   input logic [15:0] contrast_gain,
   output dpr_pkg::tag_type tag_out,
   output logic [16:0] con_out
);

   localparam int P = dpr_pkg::PIXEL_BITS;
   localparam int XW = P + 17;
   localparam logic [XW-1:0] HALF = XW'(dpr_pkg::MAXV / 2);
   localparam logic [XW-1:0] MAXV_X = XW'(dpr_pkg::MAXV);
   localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / dpr_pkg::MAXV);

   dpr_pkg::tag_type tag_in_arr [5];
   dpr_pkg::tag_type tag_ff [5];

   logic [XW-1:0] sum_in, sum_ff, sum2_ff;
   logic [16:0] est_in, est_ff;
   logic [16:0] lum_in, lum_ff;
   logic signed [34:0] cprod_in, cprod_ff;
   logic [16:0] con_in, con_ff;

   // Stage 1: weighted sum of the components plus half of the divisor.
   always_comb begin
      sum_in = XW'(19595) * XW'(tag_in.pix.in_red)
             + XW'(38470) * XW'(tag_in.pix.in_green)
             + XW'(7471) * XW'(tag_in.pix.in_blue) + HALF;
   end

   // Stage 2: quotient estimate by reciprocal multiplication.
   always_comb begin
      logic [2*XW-1:0] prod;
      prod = (2*XW)'(sum_ff) * (2*XW)'(RECIP);
      est_in = prod[XW+16:XW];
   end

   // Stage 3: one correction step yields the rounded luma.
   always_comb begin
      logic [XW-1:0] rem;
      rem = sum2_ff - XW'(est_ff) * MAXV_X;
      lum_in = est_ff + ((rem >= MAXV_X) ? 17'd1 : 17'd0);
   end

   // Stage 4: contrast gain about mid grey.
   always_comb begin
      logic signed [17:0] diff;
      logic signed [17:0] gain;
      diff = signed'({1'b0, lum_ff}) - 18'(dpr_pkg::MID_Q16);
      gain = signed'({2'b00, contrast_gain});
      cprod_in = 35'(diff) * 35'(gain);
   end

   // Stage 5: rounding to nearest, recentring and clamping to 0..1.0.
   always_comb begin
      logic signed [35:0] s;
      logic signed [21:0] w;
      s = 36'(cprod_ff) + 36'sd8192;
      w = 22'(s >>> 14) + 22'(dpr_pkg::MID_Q16);
      if (w < 0) begin
         con_in = '0;
      end else if (w > 22'(dpr_pkg::ONE_Q16)) begin
         con_in = 17'(dpr_pkg::ONE_Q16);
      end else begin
         con_in = w[16:0];
      end
   end

   // Tag chain: stage i takes the tag of stage i-1.
   always_comb begin
      tag_in_arr[0] = tag_in;
      for (int i = 1; i < 5; i++) begin
         tag_in_arr[i] = tag_ff[i-1];
      end
   end

   // Stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         for (int i = 0; i < 5; i++) begin
            tag_ff[i].valid <= tag_in_arr[i].valid;
         end
      end
      if (en) begin
         for (int i = 0; i < 5; i++) begin
            tag_ff[i].pix <= tag_in_arr[i].pix;
         end
         sum_ff <= sum_in;
         sum2_ff <= sum_ff;
         est_ff <= est_in;
         lum_ff <= lum_in;
         cprod_ff <= cprod_in;
         con_ff <= con_in;
      end
   end

   assign tag_out = tag_ff[4];
   assign con_out = con_ff;

endmodule

/* design/dpr_power.sv */
// Tone power stage group: log2 by repeated squaring, then exp2 by root products.
module dpr_power (
   input logic clock,
   input logic reset,
   input logic en,
   input dpr_pkg::tag_type tag_in,
   input logic [16:0] x_in,
   input logic [15:0] gamma,
   output dpr_pkg::tag_type tag_out,
   output logic [16:0] p_out
);

   localparam int STEPS = 16;

   // Log chain: index 0 is the normalize stage, index i+1 the i-th squaring.
   dpr_pkg::tag_type ltag_ff [STEPS+1];
   logic [30:0] lm_ff [STEPS+1];
   logic [15:0] lf_ff [STEPS+1];
   logic [4:0] lk_ff [STEPS+1];
   logic lz_ff [STEPS+1];

   // Power chain: index 0 is the exponent stage, index i+1 the i-th product.
   dpr_pkg::tag_type ptag_ff [STEPS+1];
   logic [30:0] acc_ff [STEPS+1];
   logic [15:0] pf_ff [STEPS+1];
   logic [4:0] pip_ff [STEPS+1];
   logic pkill_ff [STEPS+1];

   dpr_pkg::tag_type otag_ff;
   logic [16:0] p_ff;

   logic [30:0] m0_in;
   logic [4:0] k0_in;
   logic z0_in;
   logic [4:0] ip0_in;
   logic [15:0] fp0_in;
   logic kill0_in;
   logic [16:0] p_in;

   // Normalize: top set bit and mantissa in Q1.30.
   always_comb begin
      k0_in = '0;
      for (int b = 1; b < 17; b++) begin
         if (x_in[b]) begin
            k0_in = 5'(b);
         end
      end
      z0_in = (x_in == '0);
      m0_in = 31'(x_in) << (5'd30 - k0_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ltag_ff[0].valid <= 1'b0;
      end else if (en) begin
         ltag_ff[0].valid <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ltag_ff[0].pix <= tag_in.pix;
         lm_ff[0] <= m0_in;
         lf_ff[0] <= '0;
         lk_ff[0] <= k0_in;
         lz_ff[0] <= z0_in;
      end
   end

   // Squaring steps: each yields one fraction bit of log2.
   for (genvar i = 0; i < STEPS; i++) begin : g_log
      logic [30:0] m_in;
      logic [15:0] f_in;

      always_comb begin
         logic [61:0] sq;
         logic [31:0] t;
         sq = 62'(lm_ff[i]) * 62'(lm_ff[i]);
         t = sq[61:30];
         if (t[31]) begin
            m_in = t[31:1];
            f_in = {lf_ff[i][14:0], 1'b1};
         end else begin
            m_in = t[30:0];
            f_in = {lf_ff[i][14:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ltag_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            ltag_ff[i+1].valid <= ltag_ff[i].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ltag_ff[i+1].pix <= ltag_ff[i].pix;
            lm_ff[i+1] <= m_in;
            lf_ff[i+1] <= f_in;
            lk_ff[i+1] <= lk_ff[i];
            lz_ff[i+1] <= lz_ff[i];
         end
      end
   end

   // Exponent: y = (-log2 x) * gamma, split into integer and fraction parts.
   always_comb begin
      logic [20:0] n;
      logic [36:0] yprod;
      logic [22:0] y;
      n = (21'(5'd16 - lk_ff[STEPS]) << 16) - 21'(lf_ff[STEPS]);
      yprod = 37'(n) * 37'(gamma);
      y = yprod[36:14];
      fp0_in = y[15:0];
      kill0_in = lz_ff[STEPS] || (y[22:16] > 7'd16);
      ip0_in = y[20:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff[0].valid <= 1'b0;
      end else if (en) begin
         ptag_ff[0].valid <= ltag_ff[STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ptag_ff[0].pix <= ltag_ff[STEPS].pix;
         acc_ff[0] <= 31'd1 << 30;
         pf_ff[0] <= fp0_in;
         pip_ff[0] <= ip0_in;
         pkill_ff[0] <= kill0_in;
      end
   end

   // Product steps: multiply by 2^(-2^-(i+1)) where the fraction bit is set.
   for (genvar i = 0; i < STEPS; i++) begin : g_pow
      localparam logic [29:0] ROOT = dpr_pkg::tone_root(i);
      logic [30:0] a_in;

      always_comb begin
         logic [60:0] prod;
         prod = 61'(acc_ff[i]) * 61'(ROOT);
         if (pf_ff[i][STEPS-1-i]) begin
            a_in = prod[60:30];
         end else begin
            a_in = acc_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ptag_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            ptag_ff[i+1].valid <= ptag_ff[i].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ptag_ff[i+1].pix <= ptag_ff[i].pix;
            acc_ff[i+1] <= a_in;
            pf_ff[i+1] <= pf_ff[i];
            pip_ff[i+1] <= pip_ff[i];
            pkill_ff[i+1] <= pkill_ff[i];
         end
      end
   end

   // Final scaling to Q0.16; zero input and very deep shadows give zero.
   always_comb begin
      logic [4:0] sh;
      logic [30:0] s;
      sh = pip_ff[STEPS] + 5'd14;
      s = acc_ff[STEPS] >> sh;
      p_in = pkill_ff[STEPS] ? 17'd0 : s[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         otag_ff.valid <= 1'b0;
      end else if (en) begin
         otag_ff.valid <= ptag_ff[STEPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         otag_ff.pix <= ptag_ff[STEPS].pix;
         p_ff <= p_in;
      end
   end

   assign tag_out = otag_ff;
   assign p_out = p_ff;

endmodule

/* design/dpr_ink.sv */
// Smoothstep, ink interpolation and source blend stage group of the remap block.
module dpr_ink (
   input logic clock,
   input logic reset,
   input logic en,
   input dpr_pkg::tag_type tag_in,
   input logic [16:0] p_in,
   input dpr_pkg::cfg_type cfg,
   output logic out_valid,
   output dpr_pkg::pixel_out_type out_pix
);

   localparam int P = dpr_pkg::PIXEL_BITS;
   localparam int TW = P + 26;
   localparam int MW = TW + 18;
   localparam int NW = P + 45;
   localparam int ZW = P + 8;
   localparam logic [ZW-1:0] ZSAT = ZW'(255 * (dpr_pkg::MAXV + 1));
   localparam logic [ZW-1:0] RECIP = ZW'((64'd1 << ZW) / 255);
   localparam int STAGES = 7;

   dpr_pkg::tag_type tag_in_arr [STAGES];
   dpr_pkg::tag_type tag_ff [STAGES];

   logic [33:0] pp_in, pp_ff;
   logic [16:0] pa_ff;
   logic [16:0] sm_in, sm_ff;
   logic [7:0] sh_in [3];
   logic [7:0] sh_ff [3];
   logic signed [26:0] dp_in [3];
   logic signed [26:0] dp_ff [3];
   logic signed [TW-1:0] t_in [3];
   logic signed [TW-1:0] t_ff [3];
   logic signed [MW-1:0] tm_in [3];
   logic signed [MW-1:0] tm_ff [3];
   logic [ZW-1:0] z_in [3];
   logic [ZW-1:0] z_ff [3];
   logic [ZW-1:0] z2_ff [3];
   logic sat_in [3];
   logic sat_ff [3];
   logic sat2_ff [3];
   logic [P:0] est_in [3];
   logic [P:0] est_ff [3];
   dpr_pkg::comp_type q_in [3];
   logic valid_ff;
   dpr_pkg::pixel_out_type pix_in, pix_ff;

   // Source components of a tag by channel.
   function automatic dpr_pkg::comp_type src_of(input dpr_pkg::pixel_in_type px,
                                                input int c);
      dpr_pkg::comp_type v;
      case (c)
         0: v = px.in_red;
         1: v = px.in_green;
         default: v = px.in_blue;
      endcase
      return v;
   endfunction

   // Stage A: square of the tone value.
   assign pp_in = 34'(p_in) * 34'(p_in);

   // Stage B: smoothstep S = p^2 (3 - 2p) in Q0.16.
   always_comb begin
      logic [17:0] k;
      logic [51:0] prod;
      k = 18'd196608 - {pa_ff, 1'b0};
      prod = 52'(pp_ff) * 52'(k);
      sm_in = prod[48:32];
   end

   // Stage C: ink selection and scaled ink difference.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [7:0] hi;
         logic signed [8:0] diff;
         if (cfg.preset_select[3]) begin
            sh_in[c] = cfg.custom_shadow_ink[16-8*c +: 8];
            hi = cfg.custom_highlight_ink[16-8*c +: 8];
         end else begin
            sh_in[c] = dpr_pkg::INK_ROM[cfg.preset_select[2:0]][0][c];
            hi = dpr_pkg::INK_ROM[cfg.preset_select[2:0]][1][c];
         end
         diff = signed'({1'b0, hi}) - signed'({1'b0, sh_in[c]});
         dp_in[c] = 27'(diff) * 27'(signed'({1'b0, sm_ff}));
      end
   end

   // Stage D: duotone value and its offset from the scaled source.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [26:0] duo;
         logic signed [TW-1:0] src;
         duo = (27'(signed'({1'b0, sh_ff[c]})) <<< 16) + dp_ff[c];
         src = TW'(signed'({1'b0, src_of(tag_ff[2].pix, c)}));
         t_in[c] = TW'(duo) * TW'(dpr_pkg::MAXV) - src * TW'(255 * 65536);
      end
   end

   // Stage E: blend weight.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         tm_in[c] = MW'(t_ff[c]) * MW'(signed'({1'b0, cfg.mix_amount}));
      end
   end

   // Stage F: numerator, rounding offset and scale down by 2^32.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [NW-1:0] num;
         logic signed [NW-1:0] src;
         logic signed [NW-1:0] zf;
         src = NW'(signed'({1'b0, src_of(tag_ff[4].pix, c)}));
         num = NW'(tm_ff[c]) + ((src * NW'(255)) <<< 32);
         zf = (num + (NW'(255) <<< 31)) >>> 32;
         if (num > 0) begin
            sat_in[c] = (zf >= NW'(ZSAT));
            z_in[c] = zf[ZW-1:0];
         end else begin
            sat_in[c] = 1'b0;
            z_in[c] = '0;
         end
      end
   end

   // Stage G: quotient estimate for the division by 255.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [2*ZW-1:0] prod;
         prod = (2*ZW)'(z_ff[c]) * (2*ZW)'(RECIP);
         est_in[c] = prod[ZW+P:ZW];
      end
   end

   // Stage H: correction and clamp to full scale.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [ZW-1:0] rem;
         logic [P:0] q;
         rem = z2_ff[c] - ZW'(est_ff[c]) * ZW'(255);
         q = est_ff[c] + ((rem >= ZW'(255)) ? (P+1)'(1) : (P+1)'(0));
         q_in[c] = sat2_ff[c] ? dpr_pkg::comp_type'(dpr_pkg::MAXV) : q[P-1:0];
      end
      pix_in.out_red = q_in[0];
      pix_in.out_green = q_in[1];
      pix_in.out_blue = q_in[2];
      pix_in.out_alpha = tag_ff[STAGES-1].pix.in_alpha;
   end

   // Tag chain.
   always_comb begin
      tag_in_arr[0] = tag_in;
      for (int i = 1; i < STAGES; i++) begin
         tag_in_arr[i] = tag_ff[i-1];
      end
   end

   // Stage registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            tag_ff[i].valid <= 1'b0;
         end
         valid_ff <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            tag_ff[i].valid <= tag_in_arr[i].valid;
         end
         valid_ff <= tag_ff[STAGES-1].valid;
      end
      if (en) begin
         for (int i = 0; i < STAGES; i++) begin
            tag_ff[i].pix <= tag_in_arr[i].pix;
         end
         pp_ff <= pp_in;
         pa_ff <= p_in;
         sm_ff <= sm_in;
         for (int c = 0; c < 3; c++) begin
            sh_ff[c] <= sh_in[c];
            dp_ff[c] <= dp_in[c];
            t_ff[c] <= t_in[c];
            tm_ff[c] <= tm_in[c];
            z_ff[c] <= z_in[c];
            sat_ff[c] <= sat_in[c];
            z2_ff[c] <= z_ff[c];
            sat2_ff[c] <= sat_ff[c];
            est_ff[c] <= est_in[c];
         end
         pix_ff <= pix_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pix = pix_ff;

endmodule

/* design/duotone_pixel_remap.sv */
// Top level of the duotone pixel remap block: registers, pipeline and output skid.
//
// Each RGBA word is turned into its duotone version in a 48-stage pipeline that
// takes one word every clock while req_stall is low; the depth comes from the
// sixteen squaring steps of the log and the sixteen root products of the
// exponential, each a multiplier with its own register. A skid register at the
// output holds a word that the receiver stalls; the input stalls from the cycle
// after that until it empties. Configuration registers are to be written
// via the csr port only while no word is in flight; the block does not enforce it.
module duotone_pixel_remap (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input dpr_pkg::pixel_in_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output dpr_pkg::pixel_out_type rsp_data,
   input logic csr_write,
   input logic [dpr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input logic [dpr_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   dpr_pkg::cfg_type cfg_in, cfg_ff;
   dpr_pkg::tag_type req_tag;
   dpr_pkg::tag_type luma_tag, power_tag;
   logic [16:0] con;
   logic [16:0] tone;
   logic en;
   logic last_valid;
   dpr_pkg::pixel_out_type last_pix;
   logic skid_valid_in, skid_valid_ff;
   dpr_pkg::pixel_out_type skid_pix_ff;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (dpr_pkg::csr_index_type'(csr_index))
            dpr_pkg::CSR_PRESET_SELECT: cfg_in.preset_select = csr_data[3:0];
            dpr_pkg::CSR_CUSTOM_SHADOW: cfg_in.custom_shadow_ink = csr_data;
            dpr_pkg::CSR_CUSTOM_HIGHLIGHT: cfg_in.custom_highlight_ink = csr_data;
            dpr_pkg::CSR_CONTRAST_GAIN: cfg_in.contrast_gain = csr_data[15:0];
            dpr_pkg::CSR_TONE_EXPONENT: cfg_in.tone_exponent = csr_data[15:0];
            dpr_pkg::CSR_MIX_AMOUNT: cfg_in.mix_amount = csr_data[16:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= dpr_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The pipeline advances whenever the skid register is empty.
   assign en = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign req_tag.valid = req_valid;
   assign req_tag.pix = req_data;

   dpr_luma u_luma (
      .clock(clock),
      .reset(reset),
      .en(en),
      .tag_in(req_tag),
      .contrast_gain(cfg_ff.contrast_gain),
      .tag_out(luma_tag),
      .con_out(con)
   );

   dpr_power u_power (
      .clock(clock),
      .reset(reset),
      .en(en),
      .tag_in(luma_tag),
      .x_in(con),
      .gamma(cfg_ff.tone_exponent),
      .tag_out(power_tag),
      .p_out(tone)
   );

   dpr_ink u_ink (
      .clock(clock),
      .reset(reset),
      .en(en),
      .tag_in(power_tag),
      .p_in(tone),
      .cfg(cfg_ff),
      .out_valid(last_valid),
      .out_pix(last_pix)
   );

   // Output skid: catches the last stage's word when the receiver stalls.
   always_comb begin
      if (skid_valid_ff) begin
         skid_valid_in = rsp_stall;
      end else begin
         skid_valid_in = last_valid && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_pix_ff <= last_pix;
      end
   end

   assign rsp_valid = skid_valid_ff || last_valid;
   assign rsp_data = skid_valid_ff ? skid_pix_ff : last_pix;

   // A word caught by the skid register is the one the last stage showed.
   a_skid_capture: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> rsp_data == $past(last_pix))
      else $error("skid register caught the wrong word");

   // A stalled last-stage word moves into the skid register.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      last_valid && !skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("stalled word was not held in the skid register");

   // The skid register empties once its word is taken.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid register did not empty after delivery");

endmodule
